// ----- rtl/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg - shared types and codes for the sorted record table
// Record layout, operation and status codes, and the key compare result.
// ----------------------------------------------------------------------------
package srt_pkg;

    // Operation codes carried in the low bits of an input item
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // Status codes returned with every result item
    typedef enum logic [1:0] {
        STAT_DONE   = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_MISS   = 2'd2,
        STAT_BADPOS = 2'd3
    } status_t;

    localparam int unsigned REC_W    = 216;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned OUT_CNT_W = 6;
    localparam int unsigned DATA_W   = 224;

    // One stored record; name_high sits in the lowest bits
    typedef struct packed {
        logic [31:0] price;
        logic [23:0] volume;
        logic [31:0] name_low;
        logic [63:0] name_mid;
        logic [63:0] name_high;
    } record_t;

    // Outcome of comparing a stored record against the probe
    typedef struct packed {
        logic greater;  // stored (name, volume) sorts after the probe
        logic exact;    // name, volume and price all equal
    } cmp_t;

endpackage

// ----- rtl/srt_key_cmp.sv -----
// ----------------------------------------------------------------------------
// srt_key_cmp - record key comparator
// Orders a stored record against the probe by 160-bit big-endian name, then
// by volume, and flags an exact match on name, volume and price.
// ----------------------------------------------------------------------------
module srt_key_cmp
(
    input  srt_pkg::record_t entry,
    input  srt_pkg::record_t probe,
    output srt_pkg::cmp_t    result
);

    logic [159:0] entry_name;
    logic [159:0] probe_name;
    logic         name_eq;

    // Build the full names, first character most significant
    assign entry_name = {entry.name_high, entry.name_mid, entry.name_low};
    assign probe_name = {probe.name_high, probe.name_mid, probe.name_low};
    assign name_eq    = (entry_name == probe_name);

    // Order on name first, then volume
    assign result.greater = (entry_name > probe_name) ||
                            (name_eq && (entry.volume > probe.volume));
    assign result.exact   = name_eq && (entry.volume == probe.volume) &&
                            (entry.price == probe.price);

endmodule

// ----- rtl/sorted_record_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_record_table_core - sorted record table with insert, remove, read
// Holds up to CAPACITY records in one synchronous memory, kept ascending by
// name then volume. Insert and remove walk the memory one entry at a time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tdata: op, name, volume,
//          |           |                    |   price, position
//  m_      | out       | m_tvalid/m_tready  | m_tdata: status, count, record
//
//  One item at a time. Each memory step is an address state, then a
//  registered read data state. Insert walks down over the records it moves,
//  remove walks over every record held, and read makes a single step.
//  Reset clears the record count and control state; memory contents are
//  not cleared. A held result stalls only the next item's completion.
// ----------------------------------------------------------------------------
module sorted_record_table_core
#(
    parameter int unsigned CAPACITY = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // op[1:0], name_high[65:2], name_mid[129:66], name_low[161:130],
    // volume[185:162], price[217:186], position[223:218]
    input  logic [srt_pkg::DATA_W-1:0]  s_tdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // status[1:0], count[7:2], out_name_high[71:8], out_name_mid[135:72],
    // out_name_low[167:136], out_volume[191:168], out_price[223:192]
    output logic [srt_pkg::DATA_W-1:0]  m_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned PW    = (CNT_W > srt_pkg::POS_W) ? CNT_W : srt_pkg::POS_W;

    typedef enum logic [2:0] {
        IDLE,
        INS_RD,
        INS_CMP,
        REM_RD,
        REM_CMP,
        RD_ADDR,
        RD_DATA,
        RESP
    } state_t;

    state_t                         state_reg;
    srt_pkg::record_t               probe_reg;
    logic [srt_pkg::POS_W-1:0]      pos_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               idx_reg;
    logic                           found_reg;
    srt_pkg::status_t               res_status_reg;
    srt_pkg::record_t               res_rec_reg;
    logic [srt_pkg::DATA_W-1:0]     m_tdata_reg;
    logic                           m_tvalid_reg;

    // Record memory
    logic [srt_pkg::REC_W-1:0]      mem [CAPACITY];
    srt_pkg::record_t               rdata_reg;
    logic [IDX_W-1:0]               raddr;
    logic [IDX_W-1:0]               waddr;
    logic                           we;
    srt_pkg::record_t               wdata;

    srt_pkg::op_t                   in_op;
    srt_pkg::record_t               in_rec;
    logic [srt_pkg::POS_W-1:0]      in_pos;
    logic [PW-1:0]                  in_pos_ext;
    logic [PW-1:0]                  cnt_ext;
    logic [PW-1:0]                  pos_m1;
    logic [CNT_W-1:0]               idx_m1;
    logic [srt_pkg::OUT_CNT_W-1:0]  count_out;
    srt_pkg::cmp_t                  cmp;

    // Unpack the input item
    assign in_op      = srt_pkg::op_t'(s_tdata[1:0]);
    assign in_rec     = srt_pkg::record_t'(s_tdata[srt_pkg::REC_W+1:2]);
    assign in_pos     = s_tdata[srt_pkg::DATA_W-1 -: srt_pkg::POS_W];
    assign in_pos_ext = PW'(in_pos);
    assign cnt_ext    = PW'(count_reg);
    assign pos_m1     = PW'(pos_reg) - PW'(1);
    assign idx_m1     = idx_reg - CNT_W'(1);
    assign count_out  = cnt_ext[srt_pkg::OUT_CNT_W-1:0];

    assign s_tready = (state_reg == IDLE);
    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    srt_key_cmp u_cmp
    (
        .entry  (rdata_reg),
        .probe  (probe_reg),
        .result (cmp)
    );

    // Steer memory read and write ports for the current step
    always_comb
    begin
        raddr = '0;
        waddr = '0;
        we    = 1'b0;
        wdata = probe_reg;
        unique case (state_reg)
            INS_RD:
            begin
                raddr = idx_m1[IDX_W-1:0];
                if (idx_reg == '0)
                begin
                    we = 1'b1;
                end
            end
            INS_CMP:
            begin
                we    = 1'b1;
                waddr = idx_reg[IDX_W-1:0];
                if (cmp.greater)
                begin
                    wdata = rdata_reg;
                end
            end
            REM_RD:
            begin
                raddr = idx_reg[IDX_W-1:0];
            end
            REM_CMP:
            begin
                we    = found_reg;
                waddr = idx_m1[IDX_W-1:0];
                wdata = rdata_reg;
            end
            RD_ADDR:
            begin
                raddr = pos_m1[IDX_W-1:0];
            end
            default:
            begin
                raddr = '0;
            end
        endcase
    end

    // Write one entry and register one read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= srt_pkg::record_t'(mem[raddr]);
    end

    // Sequence each item and hold the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            probe_reg      <= '0;
            pos_reg        <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            res_status_reg <= srt_pkg::STAT_DONE;
            res_rec_reg    <= '0;
            m_tdata_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            // Drop the result once taken
            if (m_tvalid_reg && m_tready && (state_reg != RESP))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        probe_reg   <= in_rec;
                        pos_reg     <= in_pos;
                        res_rec_reg <= '0;
                        unique case (in_op)
                            srt_pkg::OP_INSERT:
                            begin
                                if (count_reg == CNT_W'(CAPACITY))
                                begin
                                    res_status_reg <= srt_pkg::STAT_FULL;
                                    state_reg      <= RESP;
                                end
                                else
                                begin
                                    idx_reg   <= count_reg;
                                    state_reg <= INS_RD;
                                end
                            end
                            srt_pkg::OP_REMOVE:
                            begin
                                idx_reg   <= '0;
                                found_reg <= 1'b0;
                                state_reg <= REM_RD;
                            end
                            srt_pkg::OP_READ:
                            begin
                                if ((in_pos_ext == '0) || (in_pos_ext > cnt_ext))
                                begin
                                    res_status_reg <= srt_pkg::STAT_BADPOS;
                                    state_reg      <= RESP;
                                end
                                else
                                begin
                                    state_reg <= RD_ADDR;
                                end
                            end
                            srt_pkg::OP_NOP:
                            begin
                                res_status_reg <= srt_pkg::STAT_DONE;
                                state_reg      <= RESP;
                            end
                        endcase
                    end
                end
                // Walk down from the top, moving greater records up one slot
                INS_RD:
                begin
                    if (idx_reg == '0)
                    begin
                        count_reg      <= count_reg + CNT_W'(1);
                        res_status_reg <= srt_pkg::STAT_DONE;
                        state_reg      <= RESP;
                    end
                    else
                    begin
                        state_reg <= INS_CMP;
                    end
                end
                INS_CMP:
                begin
                    if (cmp.greater)
                    begin
                        idx_reg   <= idx_m1;
                        state_reg <= INS_RD;
                    end
                    else
                    begin
                        count_reg      <= count_reg + CNT_W'(1);
                        res_status_reg <= srt_pkg::STAT_DONE;
                        state_reg      <= RESP;
                    end
                end
                // Walk up, finding the match and closing the gap behind it
                REM_RD:
                begin
                    if (idx_reg == count_reg)
                    begin
                        if (found_reg)
                        begin
                            count_reg      <= count_reg - CNT_W'(1);
                            res_status_reg <= srt_pkg::STAT_DONE;
                        end
                        else
                        begin
                            res_status_reg <= srt_pkg::STAT_MISS;
                        end
                        state_reg <= RESP;
                    end
                    else
                    begin
                        state_reg <= REM_CMP;
                    end
                end
                REM_CMP:
                begin
                    if (!found_reg && cmp.exact)
                    begin
                        found_reg <= 1'b1;
                    end
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= REM_RD;
                end
                // Fetch one record for a read
                RD_ADDR:
                begin
                    state_reg <= RD_DATA;
                end
                RD_DATA:
                begin
                    res_rec_reg    <= rdata_reg;
                    res_status_reg <= srt_pkg::STAT_DONE;
                    state_reg      <= RESP;
                end
                // Hand the result over once the output register is free
                RESP:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {res_rec_reg, count_out, res_status_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/srt_checker.sv -----
// ----------------------------------------------------------------------------
// srt_checker - port-level checks for the sorted record table
// Watches the result channel for stability, reset behaviour and consistent
// status, count and record fields, and the input side for one item at a time.
// ----------------------------------------------------------------------------
module srt_checker
#(
    parameter int unsigned CAPACITY = 32
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [srt_pkg::DATA_W-1:0]  m_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready
);

    localparam logic [srt_pkg::OUT_CNT_W-1:0] CAP_OUT = srt_pkg::OUT_CNT_W'(CAPACITY);

    // No result shows once reset has been seen
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // A full table reports exactly CAPACITY records
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == srt_pkg::STAT_FULL)) |-> (m_tdata[7:2] == CAP_OUT))
        else $error("full status with wrong count");

    // Record fields are zero whenever the status is not done
    a_zero_rec: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != srt_pkg::STAT_DONE)) |-> (m_tdata[223:8] == '0))
        else $error("record fields set on failed item");

    // An accepted item keeps the input closed for the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready straight after an accepted item");

endmodule

bind sorted_record_table_core srt_checker #(.CAPACITY(CAPACITY)) u_srt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
